/* src/ilt_pkg.sv */
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared types and constants for the indexed list table engine.
// ----------------------------------------------------------------------------
package ilt_pkg;

    localparam int CAPACITY = 16;

    localparam int WORD_W  = 32;
    localparam int SUM_W   = 36;
    localparam int POS_W   = 5;
    localparam int FIDX_W  = 4;
    localparam int COUNT_W = 5;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_REVERSE = 2'd2,
        OP_SEARCH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_VAL,
        S_DEL_RD0,
        S_DEL_SHIFT,
        S_REV_RLO,
        S_REV_RHI,
        S_REV_WLO,
        S_REV_WHI,
        S_SRCH
    } state_t;

    // control into the shared add/compare unit
    typedef struct packed {
        logic              sub;
        logic [WORD_W-1:0] operand;
    } unit_ctrl_t;

endpackage

/* src/ilt_ram.sv */
// ----------------------------------------------------------------------------
// ilt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/ilt_unit.sv */
// ----------------------------------------------------------------------------
// ilt_unit
// Shared arithmetic unit: running-sum add/subtract and key compare.
// ----------------------------------------------------------------------------
module ilt_unit (
    input  logic [ilt_pkg::SUM_W-1:0]  acc,
    input  ilt_pkg::unit_ctrl_t        ctrl,
    input  logic [ilt_pkg::WORD_W-1:0] key,
    input  logic [ilt_pkg::WORD_W-1:0] data,
    output logic [ilt_pkg::SUM_W-1:0]  sum,
    output logic                       eq
);

    logic [ilt_pkg::SUM_W-1:0] ext;
    logic [ilt_pkg::SUM_W-1:0] addend;

    assign ext    = {{(ilt_pkg::SUM_W - ilt_pkg::WORD_W){ctrl.operand[ilt_pkg::WORD_W-1]}},
                     ctrl.operand};
    // subtract as add of the one's complement plus carry-in
    assign addend = ctrl.sub ? ~ext : ext;
    assign sum    = acc + addend + ilt_pkg::SUM_W'(ctrl.sub);
    assign eq     = (key == data);

endmodule

/* src/indexed_list_table_engine.sv */
// ----------------------------------------------------------------------------
// indexed_list_table_engine
// Ordered list of signed words with insert, delete, reverse and search.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; busy then stays
// high until the result beat (a refused operation, a search of an empty list
// or a reverse of fewer than two entries never raises it), which is shown for
// one cycle with done high and cannot be held off. All list moves go through
// one RAM with one read and one write port: insert shifts entries up from the
// tail, then writes the value; delete reads the entry, then shifts later ones
// down; reverse swaps pairs from both ends inward; search reads entries in
// order until a match or the end. The registered result follows the last step
// in the next cycle. The running sum is kept incrementally, so total costs
// nothing extra. No clearing pass follows reset.
module indexed_list_table_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  opcode,
    input  logic signed [31:0]          value,
    input  logic [4:0]                  position,
    output logic                        done,
    output logic [1:0]                  status,
    output logic                        found,
    output logic [3:0]                  found_index,
    output logic [4:0]                  entry_count,
    output logic signed [35:0]          total
);

    localparam int AW = ilt_pkg::ADDR_W;
    localparam int CW = ilt_pkg::CNT_W;
    localparam int XW = ilt_pkg::CMP_W;
    localparam int WW = ilt_pkg::WORD_W;
    localparam int SW = ilt_pkg::SUM_W;

    ilt_pkg::state_t  state_reg, state_next;
    ilt_pkg::op_t     op_reg, op_next;
    ilt_pkg::status_t status_reg, status_next;

    logic [WW-1:0] val_reg, val_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [WW-1:0] tmp_reg, tmp_next;
    logic          wpend_reg, wpend_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic          rvalid_reg, rvalid_next;
    logic [AW-1:0] cidx_reg, cidx_next;
    logic          first_reg, first_next;
    logic          done_reg, done_next;
    logic          found_reg, found_next;
    logic [AW-1:0] fidx_reg, fidx_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;

    ilt_pkg::unit_ctrl_t unit_ctrl;
    logic [SW-1:0]       unit_sum;
    logic                unit_eq;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] cap_x;
    logic [AW-1:0] lo_inc;
    logic [AW-1:0] hi_dec;

    ilt_ram #(
        .WIDTH (WW),
        .DEPTH (ilt_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ilt_unit u_unit (
        .acc  (sum_reg),
        .ctrl (unit_ctrl),
        .key  (val_reg),
        .data (ram_rdata),
        .sum  (unit_sum),
        .eq   (unit_eq)
    );

    assign pos_x  = XW'(position);
    assign cnt_x  = XW'(count_reg);
    assign cap_x  = XW'(ilt_pkg::CAPACITY);
    assign lo_inc = lo_reg + AW'(1);
    assign hi_dec = hi_reg - AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ilt_pkg::S_IDLE;
            count_reg  <= '0;
            sum_reg    <= '0;
            wpend_reg  <= 1'b0;
            rvalid_reg <= 1'b0;
            first_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            wpend_reg  <= wpend_next;
            rvalid_reg <= rvalid_next;
            first_reg  <= first_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        ptr_reg    <= ptr_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        tmp_reg    <= tmp_next;
        wa_reg     <= wa_next;
        cidx_reg   <= cidx_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        status_next = status_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        ptr_next    = ptr_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        tmp_next    = tmp_reg;
        wa_next     = wa_reg;
        cidx_next   = cidx_reg;
        first_next  = first_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        wpend_next  = 1'b0;
        rvalid_next = 1'b0;
        done_next   = 1'b0;

        // a pending shift write always lands the beat after its read
        ram_we    = wpend_reg;
        ram_waddr = wa_reg;
        ram_wdata = ram_rdata;
        ram_raddr = ptr_reg[AW-1:0];

        unit_ctrl.sub     = 1'b0;
        unit_ctrl.operand = val_reg;

        unique case (state_reg)
            ilt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next     = ilt_pkg::op_t'(opcode);
                    val_next    = value;
                    status_next = ilt_pkg::ST_OK;
                    found_next  = 1'b0;
                    fidx_next   = '0;
                    unique case (ilt_pkg::op_t'(opcode))
                        ilt_pkg::OP_INSERT:
                        begin
                            if (cnt_x >= cap_x)
                            begin
                                status_next = ilt_pkg::ST_FULL;
                                done_next   = 1'b1;
                            end
                            else if (pos_x > cnt_x)
                            begin
                                status_next = ilt_pkg::ST_BADPOS;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                pos_next   = CW'(position);
                                state_next = (pos_x == cnt_x) ? ilt_pkg::S_INS_VAL
                                                              : ilt_pkg::S_INS_SHIFT;
                            end
                        end
                        ilt_pkg::OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ilt_pkg::ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else if (pos_x >= cnt_x)
                            begin
                                status_next = ilt_pkg::ST_BADPOS;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = CW'(position);
                                pos_next   = CW'(position);
                                state_next = ilt_pkg::S_DEL_RD0;
                            end
                        end
                        ilt_pkg::OP_REVERSE:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                lo_next    = '0;
                                hi_next    = AW'(count_reg - CW'(1));
                                state_next = ilt_pkg::S_REV_RLO;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        ilt_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = ilt_pkg::S_SRCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ilt_pkg::S_INS_SHIFT:
            begin
                ram_raddr  = AW'(ptr_reg - CW'(1));
                wpend_next = 1'b1;
                wa_next    = ptr_reg[AW-1:0];
                ptr_next   = ptr_reg - CW'(1);
                if ((ptr_reg - CW'(1)) == pos_reg)
                begin
                    state_next = ilt_pkg::S_INS_VAL;
                end
            end

            ilt_pkg::S_INS_VAL:
            begin
                // drain the last shift write first
                if (!wpend_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[AW-1:0];
                    ram_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    sum_next   = unit_sum;
                    done_next  = 1'b1;
                    state_next = ilt_pkg::S_IDLE;
                end
            end

            ilt_pkg::S_DEL_RD0:
            begin
                ptr_next   = ptr_reg + CW'(1);
                first_next = 1'b1;
                state_next = ilt_pkg::S_DEL_SHIFT;
            end

            ilt_pkg::S_DEL_SHIFT:
            begin
                // first beat: read data is the entry being removed
                if (first_reg)
                begin
                    unit_ctrl.sub     = 1'b1;
                    unit_ctrl.operand = ram_rdata;
                    sum_next          = unit_sum;
                    first_next        = 1'b0;
                end
                if (ptr_reg < count_reg)
                begin
                    ram_raddr  = ptr_reg[AW-1:0];
                    wpend_next = 1'b1;
                    wa_next    = AW'(ptr_reg - CW'(1));
                    ptr_next   = ptr_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = ilt_pkg::S_IDLE;
                end
            end

            ilt_pkg::S_REV_RLO:
            begin
                ram_raddr  = lo_reg;
                state_next = ilt_pkg::S_REV_RHI;
            end

            ilt_pkg::S_REV_RHI:
            begin
                ram_raddr  = hi_reg;
                tmp_next   = ram_rdata;
                state_next = ilt_pkg::S_REV_WLO;
            end

            ilt_pkg::S_REV_WLO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rdata;
                state_next = ilt_pkg::S_REV_WHI;
            end

            ilt_pkg::S_REV_WHI:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = tmp_reg;
                // prefetch the next low entry alongside the write
                ram_raddr = lo_inc;
                lo_next   = lo_inc;
                hi_next   = hi_dec;
                if (lo_inc < hi_dec)
                begin
                    state_next = ilt_pkg::S_REV_RHI;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ilt_pkg::S_IDLE;
                end
            end

            ilt_pkg::S_SRCH:
            begin
                if (rvalid_reg && unit_eq)
                begin
                    found_next = 1'b1;
                    fidx_next  = cidx_reg;
                    done_next  = 1'b1;
                    state_next = ilt_pkg::S_IDLE;
                end
                else if (ptr_reg < count_reg)
                begin
                    ram_raddr   = ptr_reg[AW-1:0];
                    rvalid_next = 1'b1;
                    cidx_next   = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + CW'(1);
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ilt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ilt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ilt_pkg::S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign found_index = 4'(fidx_reg);
    assign entry_count = 5'(count_reg);
    assign total       = sum_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ilt_pkg::CAPACITY))
        else $error("live count above capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !wpend_reg)
        else $error("shift write pending while idle");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ilt_pkg::ST_OK && op_reg == ilt_pkg::OP_INSERT
        |-> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list by one");

    a_found_search: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && found_reg |-> op_reg == ilt_pkg::OP_SEARCH)
        else $error("found flag on a non-search beat");

    a_reverse_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && op_reg == ilt_pkg::OP_REVERSE |-> $stable(sum_reg))
        else $error("reverse changed the running sum");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed list table engine.
// Drives insert, delete, reverse and search commands through the start/busy
// handshake and tracks the list contents in a local model. Every done beat is
// checked field by field against the oldest predicted result. A directed pass
// covers the empty, single-entry and full cases, then random traffic runs in
// phases with and without sender gaps.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 300;

    localparam int CAPACITY = ilt_pkg::CAPACITY;
    localparam int WORD_W   = ilt_pkg::WORD_W;
    localparam int SUM_W    = ilt_pkg::SUM_W;
    localparam int POS_W    = ilt_pkg::POS_W;
    localparam int FIDX_W   = ilt_pkg::FIDX_W;
    localparam int COUNT_W  = ilt_pkg::COUNT_W;

    typedef struct {
        ilt_pkg::status_t          status;
        logic                      found;
        logic [FIDX_W-1:0]         found_index;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [SUM_W-1:0]   total;
    } list_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 opcode;
    logic signed [WORD_W-1:0]   value;
    logic [POS_W-1:0]           position;
    logic                       done;
    logic [1:0]                 status;
    logic                       found;
    logic [FIDX_W-1:0]          found_index;
    logic [COUNT_W-1:0]         entry_count;
    logic signed [SUM_W-1:0]    total;

    // local copy of the list
    logic signed [WORD_W-1:0]   list_words [CAPACITY];
    int                         list_len;
    bit                         fill_up;

    list_result_t               expected_results [$];
    list_result_t               oldest_result;
    int                         error_count;
    int                         sender_idle_pct;
    int                         quiet_cycles;

    indexed_list_table_engine i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .value       (value),
        .position    (position),
        .done        (done),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .entry_count (entry_count),
        .total       (total)
    );

    always #CLK_HALF clk = ~clk;

    // Applies one command to the local list and returns the result it gives.
    function automatic list_result_t apply_list_op(ilt_pkg::op_t op,
                                                   logic signed [WORD_W-1:0] val,
                                                   logic [POS_W-1:0] pos);
        list_result_t             r;
        int                       i;
        int                       lo;
        int                       hi;
        logic signed [WORD_W-1:0] t;
        logic signed [SUM_W-1:0]  acc;
        r.status      = ilt_pkg::ST_OK;
        r.found       = 1'b0;
        r.found_index = '0;
        case (op)
            ilt_pkg::OP_INSERT:
                if (list_len >= CAPACITY)
                    r.status = ilt_pkg::ST_FULL;
                else if (int'(pos) > list_len)
                    r.status = ilt_pkg::ST_BADPOS;
                else
                begin
                    for (i = list_len; i > int'(pos); i--)
                        list_words[i] = list_words[i-1];
                    list_words[int'(pos)] = val;
                    list_len++;
                end
            ilt_pkg::OP_DELETE:
                if (list_len == 0)
                    r.status = ilt_pkg::ST_EMPTY;
                else if (int'(pos) >= list_len)
                    r.status = ilt_pkg::ST_BADPOS;
                else
                begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            ilt_pkg::OP_REVERSE:
            begin
                lo = 0;
                hi = list_len - 1;
                while (lo < hi)
                begin
                    t              = list_words[lo];
                    list_words[lo] = list_words[hi];
                    list_words[hi] = t;
                    lo++;
                    hi--;
                end
            end
            default:
            begin
                for (i = 0; i < list_len && !r.found; i++)
                begin
                    if (list_words[i] == val)
                    begin
                        r.found       = 1'b1;
                        r.found_index = FIDX_W'(i);
                    end
                end
            end
        endcase
        acc = '0;
        for (i = 0; i < list_len; i++)
            acc += list_words[i];
        r.entry_count = COUNT_W'(list_len);
        r.total       = acc;
        return r;
    endfunction

    // Sends one command once the block is free, after a random sender gap,
    // and predicts its result at the accepting edge.
    task automatic issue_op(ilt_pkg::op_t op, logic signed [WORD_W-1:0] val,
                            logic [POS_W-1:0] pos);
        @(negedge clk);
        while (busy || ($urandom_range(0, 99) < sender_idle_pct))
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start    = 1'b1;
        opcode   = op;
        value    = val;
        position = pos;
        @(posedge clk);
        expected_results.push_back(apply_list_op(op, val, pos));
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7fffffff;
                1:       return 32'sh80000000;
                2:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        else if (r < 35 && list_len > 0)
            return list_words[$urandom_range(0, list_len - 1)];
        return $urandom;
    endfunction

    task automatic test_empty_list();
        issue_op(ilt_pkg::OP_DELETE, 32'sd0, 5'd0);
        issue_op(ilt_pkg::OP_SEARCH, 32'sd0, 5'd0);
        issue_op(ilt_pkg::OP_REVERSE, 32'sd0, 5'd0);
        issue_op(ilt_pkg::OP_INSERT, 32'sd5, 5'd1);
    endtask

    task automatic test_single_entry();
        issue_op(ilt_pkg::OP_INSERT, 32'sh80000000, 5'd0);
        issue_op(ilt_pkg::OP_REVERSE, 32'sd0, 5'd0);
        issue_op(ilt_pkg::OP_DELETE, 32'sd0, 5'd1);
        issue_op(ilt_pkg::OP_SEARCH, 32'sh80000000, 5'd31);
    endtask

    task automatic test_full_list();
        int i;
        issue_op(ilt_pkg::OP_INSERT, 32'sh7fffffff, 5'd1);
        // fill at the head, the tail and the middle in turn
        for (i = 2; i < CAPACITY; i++)
            issue_op(ilt_pkg::OP_INSERT,
                     (i == 9) ? -32'sd1 : (i % 2 ? 32'sh80000000 : 32'sh7fffffff),
                     POS_W'((i % 3 == 0) ? 0 : (i % 3 == 1) ? i : i / 2));
        // full wins over a bad position
        issue_op(ilt_pkg::OP_INSERT, 32'sd7, 5'd31);
        issue_op(ilt_pkg::OP_SEARCH, 32'sh7fffffff, 5'd0);
        issue_op(ilt_pkg::OP_SEARCH, 32'sd1, 5'd0);
        issue_op(ilt_pkg::OP_REVERSE, 32'sd0, 5'd0);
        issue_op(ilt_pkg::OP_DELETE, 32'sd0, 5'd16);
        issue_op(ilt_pkg::OP_DELETE, 32'sd0, 5'd15);
        issue_op(ilt_pkg::OP_DELETE, 32'sd0, 5'd0);
    endtask

    task automatic test_random_traffic(int n_items, int idle_pct);
        int                       k;
        int                       r;
        ilt_pkg::op_t             op;
        logic signed [WORD_W-1:0] val;
        logic [POS_W-1:0]         pos;
        sender_idle_pct = idle_pct;
        for (k = 0; k < n_items; k++)
        begin
            // swing the list between empty and full so both limits get hit
            if (list_len == CAPACITY)
                fill_up = 1'b0;
            else if (list_len == 0)
                fill_up = 1'b1;
            if ($urandom_range(0, 99) < 8)
            begin
                op  = ilt_pkg::op_t'($urandom_range(0, 3));
                val = $urandom;
                pos = POS_W'($urandom_range(0, 31));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < (fill_up ? 55 : 25))
                    op = ilt_pkg::OP_INSERT;
                else if (r < 75)
                    op = ilt_pkg::OP_DELETE;
                else if (r < 85)
                    op = ilt_pkg::OP_REVERSE;
                else
                    op = ilt_pkg::OP_SEARCH;
                val = pick_word();
                if (op == ilt_pkg::OP_INSERT)
                    pos = POS_W'($urandom_range(0, list_len));
                else if (list_len > 0)
                    pos = POS_W'($urandom_range(0, list_len - 1));
                else
                    pos = '0;
            end
            issue_op(op, val, pos);
        end
    endtask

    task automatic flag_field(string name, longint exp_v, longint act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        error_count++;
    endtask

    // one result beat per done
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, status %0d, total %0d",
                         $time, status, total);
                error_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (oldest_result.status !== status)
                    flag_field("status", oldest_result.status, status);
                if (oldest_result.found !== found)
                    flag_field("found", oldest_result.found, found);
                if (oldest_result.found_index !== found_index)
                    flag_field("found_index", oldest_result.found_index, found_index);
                if (oldest_result.entry_count !== entry_count)
                    flag_field("entry_count", oldest_result.entry_count, entry_count);
                if (oldest_result.total !== total)
                    flag_field("total", oldest_result.total, total);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        opcode          = ilt_pkg::OP_INSERT;
        value           = '0;
        position        = '0;
        list_len        = 0;
        fill_up         = 1'b1;
        error_count     = 0;
        sender_idle_pct = 0;
        quiet_cycles    = 0;
        for (int i = 0; i < CAPACITY; i++)
            list_words[i] = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_single_entry();
        test_full_list();
        test_random_traffic(RANDOM_ITEMS, 0);
        test_random_traffic(RANDOM_ITEMS, 82);
        test_random_traffic(RANDOM_ITEMS, 34);
        test_random_traffic(RANDOM_ITEMS, 0);

        @(negedge clk);
        start = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
